### rtl/core/mtcf_pkg.sv
// Shared constants, character codes and transaction types of the move text cleanup filter.
// Used by the front end, queue, back end, top level and checker; depends on nothing else.
`default_nettype none

package mtcf_pkg;

	localparam int unsigned NEST_LIMIT  = 255;
	localparam int unsigned HOLD_LEN    = 7;
	localparam int unsigned DROP_MAX    = 6;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam int unsigned DEPTH_W = $clog2(NEST_LIMIT + 1);
	localparam int unsigned IDX_W   = $clog2(HOLD_LEN);
	localparam int unsigned HC_W    = $clog2(HOLD_LEN + 1);
	localparam int unsigned CNT_W   = $clog2(HOLD_LEN + 2);
	localparam int unsigned QPTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned QCNT_W  = $clog2(QUEUE_DEPTH + 1);

	localparam logic [DEPTH_W-1:0] NEST_MAX = DEPTH_W'(NEST_LIMIT);

	localparam logic [7:0] CH_BLANK  = 8'h20;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_ONE    = 8'h31;
	localparam logic [7:0] CH_TWO    = 8'h32;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_EQ     = 8'h3D;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UZ     = 8'h5A;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LZ     = 8'h7A;
	localparam logic [7:0] CH_LBRACE = 8'h7B;
	localparam logic [7:0] CH_RBRACE = 8'h7D;

	typedef struct packed {
		logic       action;
		logic [7:0] char_in;
	} item_t;

	typedef struct packed {
		logic [6:0] char_out;
		logic       has_char;
		logic       text_done;
	} result_t;

	// One queued job: an optional leading blank, then the first n held characters.
	typedef struct packed {
		logic                     blank;
		logic [HC_W-1:0]          n;
		logic [HOLD_LEN-1:0][6:0] chars;
		logic                     done;
	} job_t;

	typedef struct packed {
		logic full;
		logic nonempty;
	} qstat_t;

endpackage

`default_nettype wire

### rtl/core/move_text_cleanup_filter_unit.sv
// The first result of an item is registered in the job queue and then in the output register.
// Throughput: one input item per cycle while the two-entry job queue has room; the back
// end emits one result per cycle while result_stall is low, and an item's job holds it until all its results are out.
// Reset (arst_n low) clears all control state at once; the held token buffer is not reset.
// Top level of the move text cleanup filter: front end, job queue and back end.
// Depends on mtcf_pkg, mtcf_front, mtcf_queue and mtcf_back.
`default_nettype none

module move_text_cleanup_filter_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_stall,
	input  wire mtcf_pkg::item_t   item,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output mtcf_pkg::result_t      result
);

	logic              accept, push, pop;
	mtcf_pkg::job_t    job, head;
	mtcf_pkg::qstat_t  stat;

	assign item_stall = stat.full;
	assign accept     = item_valid && !item_stall;

	mtcf_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.item   (item),
		.push   (push),
		.job    (job)
	);

	mtcf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.head     (head),
		.stat     (stat)
	);

	mtcf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.stat         (stat),
		.pop          (pop),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

### rtl/core/mtcf_front.sv
// Front end of the move text cleanup filter: classifies each byte, tracks skip modes
// and the held token, and issues output jobs. Depends on mtcf_pkg.
`default_nettype none

module mtcf_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           accept,
	input  wire mtcf_pkg::item_t item,
	output logic                push,
	output mtcf_pkg::job_t      job
);

	typedef enum logic [2:0] {
		MODE_NORMAL  = 3'd0,
		MODE_NAG     = 3'd1,
		MODE_BRACE   = 3'd2,
		MODE_ANGLE   = 3'd3,
		MODE_PAREN   = 3'd4,
		MODE_MOVENUM = 3'd5
	} mode_t;

	mode_t                                         mode_q, mode_d;
	logic [mtcf_pkg::DEPTH_W-1:0]                  depth_q, depth_d;
	logic                                          pb_q, pb_d;
	logic                                          ea_q, ea_d;
	logic                                          bp_q, bp_d;
	logic                                          long_q, long_d;
	logic [mtcf_pkg::HC_W-1:0]                     hc_q, hc_d, hc_end;
	logic [mtcf_pkg::HOLD_LEN-1:0][6:0]            hold_q, hold_d;
	logic [mtcf_pkg::IDX_W-1:0]                    last_idx;
	logic                                          is_result;
	logic                                          plain, take;
	logic [7:0]                                    c;

	function automatic logic is_num(input logic [7:0] b);
		return (b >= mtcf_pkg::CH_ZERO) && (b <= mtcf_pkg::CH_NINE);
	endfunction

	function automatic logic is_kept(input logic [7:0] b);
		return is_num(b) || ((b >= mtcf_pkg::CH_UA) && (b <= mtcf_pkg::CH_UZ)) ||
			((b >= mtcf_pkg::CH_LA) && (b <= mtcf_pkg::CH_LZ)) ||
			(b == mtcf_pkg::CH_DOLLAR) || (b == mtcf_pkg::CH_STAR) ||
			(b == mtcf_pkg::CH_LPAREN) || (b == mtcf_pkg::CH_LBRACE) ||
			(b == mtcf_pkg::CH_LT) || (b == mtcf_pkg::CH_SLASH) ||
			(b == mtcf_pkg::CH_MINUS) || (b == mtcf_pkg::CH_EQ);
	endfunction

	assign c        = item.char_in;
	assign last_idx = mtcf_pkg::IDX_W'(hc_q - 1'b1);

	// A held token that is a whole game result is dropped at the end of the text.
	always_comb begin
		is_result = 1'b0;
		if (!long_q && hc_q == mtcf_pkg::HC_W'(6)) begin
			is_result = ({1'b0, hold_q[0]} == mtcf_pkg::CH_SLASH) &&
				({1'b0, hold_q[1]} == mtcf_pkg::CH_TWO) &&
				({1'b0, hold_q[2]} == mtcf_pkg::CH_MINUS) &&
				({1'b0, hold_q[3]} == mtcf_pkg::CH_ONE) &&
				({1'b0, hold_q[4]} == mtcf_pkg::CH_SLASH) &&
				({1'b0, hold_q[5]} == mtcf_pkg::CH_TWO);
		end else if (!long_q && hc_q == mtcf_pkg::HC_W'(2)) begin
			is_result = ({1'b0, hold_q[0]} == mtcf_pkg::CH_MINUS) &&
				(({1'b0, hold_q[1]} == mtcf_pkg::CH_ZERO) ||
				({1'b0, hold_q[1]} == mtcf_pkg::CH_ONE));
		end
	end

	always_comb begin
		mode_d    = mode_q;
		depth_d   = depth_q;
		pb_d      = pb_q;
		ea_d      = ea_q;
		bp_d      = bp_q;
		long_d    = long_q;
		hc_d      = hc_q;
		hold_d    = hold_q;
		hc_end    = hc_q;
		plain     = 1'b0;
		take      = 1'b0;
		job.blank = 1'b0;
		job.n     = '0;
		job.chars = hold_q;
		job.done  = 1'b0;

		if (item.action) begin
			if (hc_q != '0) begin
				if ({1'b0, hold_q[last_idx]} == mtcf_pkg::CH_STAR) begin
					hc_end = hc_q - 1'b1;
				end else if (is_result) begin
					hc_end = '0;
				end
			end
			job.blank = bp_q && (hc_end != '0);
			job.n     = hc_end;
			job.done  = 1'b1;
			mode_d    = MODE_NORMAL;
			depth_d   = '0;
			pb_d      = 1'b1;
			ea_d      = 1'b0;
			bp_d      = 1'b0;
			long_d    = 1'b0;
			hc_d      = '0;
		end else begin
			unique case (mode_q)
				MODE_NAG: begin
					if (!is_num(c)) begin
						mode_d = MODE_NORMAL;
						plain  = 1'b1;
					end
				end
				MODE_MOVENUM: begin
					if (!is_num(c) && c != mtcf_pkg::CH_DOT) begin
						mode_d = MODE_NORMAL;
						plain  = 1'b1;
					end
				end
				MODE_BRACE: begin
					if (c == mtcf_pkg::CH_RBRACE) mode_d = MODE_NORMAL;
				end
				MODE_ANGLE: begin
					if (c == mtcf_pkg::CH_GT) mode_d = MODE_NORMAL;
				end
				MODE_PAREN: begin
					if (c == mtcf_pkg::CH_RPAREN) begin
						if (depth_q <= mtcf_pkg::DEPTH_W'(1)) begin
							depth_d = '0;
							mode_d  = MODE_NORMAL;
						end else begin
							depth_d = depth_q - 1'b1;
						end
					end else if (c == mtcf_pkg::CH_LPAREN) begin
						if (depth_q < mtcf_pkg::NEST_MAX) depth_d = depth_q + 1'b1;
					end
				end
				default: begin
					mode_d = MODE_NORMAL;
					plain  = 1'b1;
				end
			endcase

			if (plain) begin
				if (c[7] || !is_kept(c)) begin
					pb_d = 1'b1;
				end else if (c == mtcf_pkg::CH_DOLLAR) begin
					mode_d = MODE_NAG;
					pb_d   = 1'b1;
				end else if (c == mtcf_pkg::CH_LBRACE) begin
					mode_d = MODE_BRACE;
					pb_d   = 1'b1;
				end else if (c == mtcf_pkg::CH_LT) begin
					mode_d = MODE_ANGLE;
					pb_d   = 1'b1;
				end else if (c == mtcf_pkg::CH_LPAREN) begin
					mode_d  = MODE_PAREN;
					depth_d = mtcf_pkg::DEPTH_W'(1);
					pb_d    = 1'b1;
				end else if (is_num(c) && pb_q) begin
					mode_d = MODE_MOVENUM;
				end else begin
					take = 1'b1;
				end
			end

			if (take) begin
				if (pb_q) begin
					// New token: what is still held of the previous one goes out, with its blank if owed.
					job.blank = bp_q && (hc_q != '0);
					job.n     = hc_q;
					ea_d      = ea_q || (hc_q != '0);
					bp_d      = ea_q || (hc_q != '0);
					hold_d[0] = c[6:0];
					hc_d      = mtcf_pkg::HC_W'(1);
					long_d    = 1'b0;
				end else begin
					if (bp_q && (long_q || hc_q >= mtcf_pkg::HC_W'(mtcf_pkg::DROP_MAX))) begin
						job.blank = 1'b1;
						bp_d      = 1'b0;
						ea_d      = 1'b1;
					end
					if (hc_q == mtcf_pkg::HC_W'(mtcf_pkg::HOLD_LEN)) begin
						job.n = mtcf_pkg::HC_W'(1);
						for (int i = 0; i < mtcf_pkg::HOLD_LEN - 1; i++) begin
							hold_d[i] = hold_q[i+1];
						end
						hold_d[mtcf_pkg::HOLD_LEN-1] = c[6:0];
						long_d = 1'b1;
						ea_d   = 1'b1;
					end else begin
						hold_d[hc_q[mtcf_pkg::IDX_W-1:0]] = c[6:0];
						hc_d = hc_q + 1'b1;
					end
				end
				pb_d = 1'b0;
			end
		end
	end

	assign push = accept && (job.blank || (job.n != '0) || job.done);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			depth_q <= '0;
			pb_q    <= 1'b1;
			ea_q    <= 1'b0;
			bp_q    <= 1'b0;
			long_q  <= 1'b0;
			hc_q    <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			depth_q <= depth_d;
			pb_q    <= pb_d;
			ea_q    <= ea_d;
			bp_q    <= bp_d;
			long_q  <= long_d;
			hc_q    <= hc_d;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) hold_q <= hold_d;
	end

endmodule

`default_nettype wire

### rtl/core/mtcf_queue.sv
// Short job queue between the front and back ends of the move text cleanup filter.
// Depends on mtcf_pkg for the job type and depth.
`default_nettype none

module mtcf_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire mtcf_pkg::job_t  push_job,
	input  wire logic            pop,
	output mtcf_pkg::job_t       head,
	output mtcf_pkg::qstat_t     stat
);

	mtcf_pkg::job_t                 entry_q [mtcf_pkg::QUEUE_DEPTH];
	logic [mtcf_pkg::QPTR_W-1:0]    wr_q, rd_q;
	logic [mtcf_pkg::QCNT_W-1:0]    cnt_q;

	function automatic logic [mtcf_pkg::QPTR_W-1:0] wrap_inc(
		input logic [mtcf_pkg::QPTR_W-1:0] p);
		return (p == mtcf_pkg::QPTR_W'(mtcf_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign head          = entry_q[rd_q];
	assign stat.full     = (cnt_q == mtcf_pkg::QCNT_W'(mtcf_pkg::QUEUE_DEPTH));
	assign stat.nonempty = (cnt_q != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wrap_inc(wr_q);
			if (pop) rd_q <= wrap_inc(rd_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_q] <= push_job;
	end

endmodule

`default_nettype wire

### rtl/core/mtcf_back.sv
// Back end of the move text cleanup filter: walks the head job one character per cycle
// into the output register while result_stall is low. Depends on mtcf_pkg.
`default_nettype none

module mtcf_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire mtcf_pkg::job_t    head,
	input  wire mtcf_pkg::qstat_t  stat,
	output logic                   pop,
	input  wire logic              result_stall,
	output logic                   result_valid,
	output mtcf_pkg::result_t      result
);

	logic [mtcf_pkg::CNT_W-1:0] pos_q, total, idx;
	logic                       last, load, valid_q;
	mtcf_pkg::result_t          next, result_q;

	assign total = mtcf_pkg::CNT_W'(head.n) + mtcf_pkg::CNT_W'(head.blank);
	assign idx   = head.blank ? pos_q - 1'b1 : pos_q;
	assign last  = (total == '0) || (pos_q == total - 1'b1);

	always_comb begin
		next.has_char  = (total != '0);
		next.text_done = head.done && last;
		if (total == '0) begin
			next.char_out = '0;
		end else if (head.blank && pos_q == '0) begin
			next.char_out = mtcf_pkg::CH_BLANK[6:0];
		end else begin
			next.char_out = head.chars[idx[mtcf_pkg::IDX_W-1:0]];
		end
	end

	assign load         = stat.nonempty && (!valid_q || !result_stall);
	assign pop          = load && last;
	assign result_valid = valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			pos_q   <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				pos_q   <= last ? '0 : pos_q + 1'b1;
			end else if (!result_stall) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) result_q <= next;
	end

endmodule

`default_nettype wire

### rtl/core/mtcf_checker.sv
// Port-level assertions for the move text cleanup filter, bound to its top level.
// Depends on mtcf_pkg and move_text_cleanup_filter_unit.
`default_nettype none

module mtcf_checker (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              item_valid,
	input wire logic              item_stall,
	input wire mtcf_pkg::item_t   item,
	input wire logic              result_valid,
	input wire logic              result_stall,
	input wire mtcf_pkg::result_t result
);

	// A stalled input transaction is offered unchanged until it is taken.
	a_item_hold: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_stall |=> item_valid && $stable(item))
		else $error("input changed while stalled");

	// A stalled result transaction holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// An empty result only closes a text.
	a_empty_closes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result.has_char |-> result.text_done && (result.char_out == '0))
		else $error("empty result that does not close the text");

	// A trailing blank is never given.
	a_no_trailing_blank: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.has_char && result.text_done |->
			({1'b0, result.char_out} != mtcf_pkg::CH_BLANK))
		else $error("text closed on a blank");

	// Characters carried out are never below the blank, so never control characters.
	a_printable: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.has_char |->
			({1'b0, result.char_out} >= mtcf_pkg::CH_BLANK))
		else $error("control character in the output");

endmodule

bind move_text_cleanup_filter_unit mtcf_checker u_mtcf_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
